// ===== rtl/wrp_pkg.sv =====
package wrp_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned WV_W      = 16;
  localparam int unsigned RAND_W    = 17;
  localparam int unsigned SUM_W     = 22;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned RBIT_W    = $clog2(RAND_W);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PICK  = 1'b1;

endpackage

// ===== rtl/weighted_random_pick.sv =====
// weighted_random_pick: roulette wheel selection over a table of weights.
// Input channel (in_valid_i / in_stall_o) carries one command per item:
//   command 0 writes weight_value_i to entry entry_index_i and updates the
//   running total; command 1 picks an entry with rand_fraction_i (Q1.16).
// Output channel (out_valid_o / out_stall_i) returns one item per command:
//   found_o, chosen_index_o and weight_sum_o (total after the command).
// cfg_we_i / cfg_wdata_i set object_count, the number of entries a pick sees.
// After reset the table is cleared one entry per cycle, with in_stall_o high;
// the config port is taken at any time.
// A write reads the old weight, subtracts it, adds the new one and stores
// it, then gives the result. A pick makes one pass through the table memory
// to sum the considered weights, a shift-add multiply, and a second pass to
// find the span; all of it runs through one shared adder.
// A pick with a zero fraction or no entries goes straight to the result.
// One item is in work at a time. The result sits in an output register, so
// the next item is taken while a result waits; a stalled receiver holds the
// result and blocks completion of the following item only.
module weighted_random_pick #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrp_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [wrp_pkg::IDX_W-1:0]         entry_index_i,
  input  logic [wrp_pkg::WV_W-1:0]          weight_value_i,
  input  logic [wrp_pkg::RAND_W-1:0]        rand_fraction_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [wrp_pkg::IDX_W-1:0]         chosen_index_o,
  output logic [wrp_pkg::SUM_W-1:0]         weight_sum_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WB = WEIGHT_BITS;
  localparam int unsigned SW = WEIGHT_BITS + AW;
  localparam int unsigned PW = wrp_pkg::RAND_W + SW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WSUB  = 4'd3;
  localparam logic [3:0] S_WADD  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [WB-1:0] mem [MAX_ENTRIES];

  logic [3:0]                      state_q, state_d;
  logic [wrp_pkg::CNT_W-1:0]       count_q;
  logic [SW-1:0]                   total_q, total_d;
  logic [CW-1:0]                   ptr_q, ptr_d;
  logic [CW-1:0]                   n_q, n_d;
  logic                            pend_q, pend_d;
  logic [AW-1:0]                   didx_q, didx_d;
  logic [PW-1:0]                   acc_q, acc_d;
  logic [SW-1:0]                   cum_q, cum_d;
  logic [wrp_pkg::RBIT_W-1:0]      bit_q, bit_d;
  logic [WB-1:0]                   wv_q, wv_d;
  logic [wrp_pkg::RAND_W-1:0]      r_q, r_d;
  logic                            res_found_q, res_found_d;
  logic [wrp_pkg::IDX_W-1:0]       res_idx_q, res_idx_d;
  logic [WB-1:0]                   rd_data_q;

  logic                            out_valid_q, out_valid_d;
  logic                            out_found_q, out_found_d;
  logic [wrp_pkg::IDX_W-1:0]       out_idx_q, out_idx_d;
  logic [wrp_pkg::SUM_W-1:0]       out_sum_q, out_sum_d;

  logic                            mem_we;
  logic [WB-1:0]                   mem_wdata;
  logic                            in_acc;
  logic                            issue;
  logic                            hit;

  // shared adder / subtractor
  logic [PW-1:0] add_a, add_b, add_res;
  logic          add_sub;

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + PW'(add_sub);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (ptr_q < n_q);
  assign hit        = (rd_data_q != '0) &&
                      (acc_q <= PW'({add_res[SW-1:0], {wrp_pkg::FRAC_BITS{1'b0}}}));

  always_comb begin
    add_a   = PW'(total_q);
    add_b   = PW'(wv_q);
    add_sub = 1'b0;
    case (state_q)
      S_WSUB: begin
        add_b   = PW'(rd_data_q);
        add_sub = 1'b1;
      end
      S_SUM: begin
        add_a = acc_q;
        add_b = PW'(rd_data_q);
      end
      S_MUL: begin
        add_a = {acc_q[PW-2:0], 1'b0};
        add_b = r_q[bit_q] ? PW'(cum_q) : '0;
      end
      S_WALK: begin
        add_a = PW'(cum_q);
        add_b = PW'(rd_data_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    ptr_d       = ptr_q;
    n_d         = n_q;
    pend_d      = pend_q;
    didx_d      = didx_q;
    acc_d       = acc_q;
    cum_d       = cum_q;
    bit_d       = bit_q;
    wv_d        = wv_q;
    r_d         = r_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_sum_d   = out_sum_q;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + CW'(1);
        if (ptr_q == CW'(MAX_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          wv_d        = WB'(weight_value_i);
          r_d         = rand_fraction_i;
          res_found_d = 1'b0;
          res_idx_d   = '0;
          acc_d       = '0;
          ptr_d       = '0;
          pend_d      = 1'b0;
          if (int'(count_q) > int'(MAX_ENTRIES)) begin
            n_d = CW'(MAX_ENTRIES);
          end else begin
            n_d = CW'(count_q);
          end
          if (command_i == wrp_pkg::CMD_WRITE) begin
            if (int'(entry_index_i) < int'(MAX_ENTRIES)) begin
              ptr_d   = CW'(entry_index_i);
              state_d = S_WRD;
            end else begin
              state_d = S_DONE;
            end
          end else if (rand_fraction_i == '0 || count_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_WRD: begin
        state_d = S_WSUB;
      end
      S_WSUB: begin
        total_d = add_res[SW-1:0];
        state_d = S_WADD;
      end
      S_WADD: begin
        total_d   = add_res[SW-1:0];
        mem_we    = 1'b1;
        mem_wdata = wv_q;
        state_d   = S_DONE;
      end
      S_SUM: begin
        if (pend_q) begin
          acc_d = add_res;
        end
        pend_d = issue;
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
        end else if (!pend_q) begin
          // table sum done, start the shift-add multiply r * sum
          if (acc_q == '0) begin
            state_d = S_DONE;
          end else begin
            cum_d   = acc_q[SW-1:0];
            acc_d   = '0;
            bit_d   = wrp_pkg::RBIT_W'(wrp_pkg::RAND_W - 1);
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_d = add_res;
        bit_d = bit_q - wrp_pkg::RBIT_W'(1);
        if (bit_q == '0) begin
          cum_d   = '0;
          ptr_d   = '0;
          pend_d  = 1'b0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        pend_d = issue;
        if (issue) begin
          ptr_d  = ptr_q + CW'(1);
          didx_d = ptr_q[AW-1:0];
        end
        // r nonzero and earlier spans missed, so only the upper bound is left
        if (pend_q) begin
          cum_d = add_res[SW-1:0];
          if (hit) begin
            res_found_d = 1'b1;
            res_idx_d   = wrp_pkg::IDX_W'(didx_q);
            state_d     = S_DONE;
          end
        end
        if (!issue && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_idx_d   = res_idx_q;
          out_sum_d   = wrp_pkg::SUM_W'(total_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q[AW-1:0]] <= mem_wdata;
    end
    rd_data_q <= mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      total_q     <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      total_q     <= total_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    didx_q      <= didx_d;
    acc_q       <= acc_d;
    cum_q       <= cum_d;
    bit_q       <= bit_d;
    wv_q        <= wv_d;
    r_q         <= r_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_sum_q   <= out_sum_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign chosen_index_o = out_idx_q;
  assign weight_sum_o   = out_sum_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after taking an item");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result shown without finishing an item");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_SUM) |-> ptr_q <= n_q)
    else $error("table pointer beyond considered entries");

  a_found_on_pick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_found_q) |-> r_q != '0)
    else $error("entry found with zero fraction");

endmodule
